// ----- rtl/prr_pkg.sv -----
`default_nettype none
package prr_pkg;

    typedef struct packed {
        logic [31:0] seq;
        logic [10:0] len;
        logic        ch;
        logic [7:0]  tag;
        logic        fin;
        logic        bad_ch;
    } pkt_t;

    typedef struct packed {
        logic [31:0] offset;
        logic [10:0] len;
        logic [7:0]  tag;
    } entry_t;

    typedef struct packed {
        logic kind;
        logic [31:0] seq;
        logic [10:0] len;
        logic        ch;
        logic [7:0]  tag;
        logic        fin;
        logic        done;
        logic        run_end;
    } result_t;

    localparam logic KIND_ACK     = 1'b0;
    localparam logic KIND_DELIVER = 1'b1;

endpackage
`default_nettype wire

// ----- rtl/prr_front.sv -----
`default_nettype none
module prr_front #(
    parameter int MAX_PAYLOAD  = 1024,
    parameter int NUM_CHANNELS = 2,
    parameter int TAG_BITS     = 8
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               push,
    output logic              full,
    input  wire  [31:0]       seq_num,
    input  wire  [10:0]       length,
    input  wire               channel,
    input  wire  [7:0]        payload_tag,
    input  wire               final_packet,
    output logic              pkt_valid,
    output prr_pkg::pkt_t     pkt,
    input  wire               pkt_take
);
    localparam logic [7:0] TAG_MASK =
        (TAG_BITS >= 8) ? 8'hFF : 8'((1 << TAG_BITS) - 1);

    prr_pkg::pkt_t slot_reg [2];
    logic          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]    cnt_reg;
    prr_pkg::pkt_t in_pkt;
    logic          do_push, do_pop;

    // classify: saturate length, mask tag, flag bad channel
    always_comb
    begin
        in_pkt.seq = seq_num;
        if (17'(length) > 17'(MAX_PAYLOAD))
            in_pkt.len = 11'(MAX_PAYLOAD);
        else
            in_pkt.len = length;
        in_pkt.ch     = channel;
        in_pkt.tag    = payload_tag & TAG_MASK;
        in_pkt.fin    = final_packet;
        in_pkt.bad_ch = 5'(channel) >= 5'(NUM_CHANNELS);
    end

    assign full      = cnt_reg == 2'd2;
    assign pkt_valid = cnt_reg != 2'd0;
    assign pkt       = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pkt_valid && pkt_take;

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= in_pkt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(do_push) - 2'(do_pop);
        end
    end
endmodule
`default_nettype wire

// ----- rtl/prr_back.sv -----
`default_nettype none
module prr_back #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               pkt_valid,
    input  prr_pkg::pkt_t     pkt,
    output logic              pkt_take,
    output logic              res_valid,
    output prr_pkg::result_t  res,
    input  wire               res_pop
);
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SRCH_A = 4'd1;
    localparam logic [3:0] S_SRCH_D = 4'd2;
    localparam logic [3:0] S_ACK    = 4'd3;
    localparam logic [3:0] S_SHF_A  = 4'd4;
    localparam logic [3:0] S_SHF_D  = 4'd5;
    localparam logic [3:0] S_INSERT = 4'd6;
    localparam logic [3:0] S_P1_A   = 4'd7;
    localparam logic [3:0] S_P1_D   = 4'd8;
    localparam logic [3:0] S_EM_DEL = 4'd9;
    localparam logic [3:0] S_EM_ACK = 4'd10;
    localparam logic [3:0] S_P2_A   = 4'd11;
    localparam logic [3:0] S_P2_D   = 4'd12;
    localparam logic [3:0] S_COMMIT = 4'd13;

    prr_pkg::entry_t mem [TABLE_DEPTH];
    prr_pkg::entry_t rd_q_reg;

    logic [3:0]       state_reg;
    prr_pkg::pkt_t    cur_reg;
    logic [31:0]      expected_reg, exp1_reg, exp2_reg;
    logic             last_seen_reg, dup_reg, any_del_reg, done_reg;
    logic [IDX_W-1:0] head_reg;
    logic [CNT_W-1:0] count_reg, i_reg, m_reg, last_del_reg;
    logic             out_valid_reg;
    prr_pkg::result_t out_reg;

    logic             emit, emit_ok;
    prr_pkg::result_t emit_res;
    logic [CNT_W-1:0] rd_lidx, wr_lidx;
    logic [IDX_W-1:0] rd_addr, wr_addr;
    logic             we;
    prr_pkg::entry_t  wd;

    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] h,
                                              input logic [CNT_W-1:0] l);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(h) + (CNT_W+1)'(l);
        if (s >= (CNT_W+1)'(TABLE_DEPTH))
            s = s - (CNT_W+1)'(TABLE_DEPTH);
        return IDX_W'(s);
    endfunction

    assign emit_ok  = !out_valid_reg || res_pop;
    assign pkt_take = state_reg == S_IDLE;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // table port addresses
    always_comb
    begin
        rd_lidx = (state_reg == S_SHF_A) ? i_reg - CNT_W'(1) : i_reg;
        wr_lidx = i_reg;
        rd_addr = phys(head_reg, rd_lidx);
        wr_addr = phys(head_reg, wr_lidx);
        we = 1'b0;
        wd = rd_q_reg;
        if (state_reg == S_SHF_D)
            we = 1'b1;
        else if (state_reg == S_INSERT)
        begin
            we = 1'b1;
            wd.offset = cur_reg.seq;
            wd.len    = cur_reg.len;
            wd.tag    = cur_reg.tag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wr_addr] <= wd;
        rd_q_reg <= mem[rd_addr];
    end

    // result produced in the current state
    always_comb
    begin
        emit = 1'b0;
        emit_res = '0;
        emit_res.done = done_reg;
        unique case (state_reg)
            S_ACK:
            begin
                emit = !(!dup_reg && count_reg == CNT_W'(TABLE_DEPTH));
                emit_res.kind    = prr_pkg::KIND_ACK;
                emit_res.seq     = cur_reg.seq;
                emit_res.ch      = cur_reg.ch;
                emit_res.fin     = cur_reg.fin;
                emit_res.done    = (last_seen_reg || cur_reg.fin) && dup_reg
                                   && count_reg == '0;
                emit_res.run_end = 1'b1;
            end
            S_EM_DEL:
            begin
                emit = 1'b1;
                emit_res.kind = prr_pkg::KIND_DELIVER;
                emit_res.seq  = cur_reg.seq;
                emit_res.len  = cur_reg.len;
                emit_res.tag  = cur_reg.tag;
            end
            S_EM_ACK:
            begin
                emit = 1'b1;
                emit_res.kind    = prr_pkg::KIND_ACK;
                emit_res.seq     = cur_reg.seq;
                emit_res.ch      = cur_reg.ch;
                emit_res.fin     = cur_reg.fin;
                emit_res.run_end = !any_del_reg;
            end
            S_P2_D:
            begin
                emit = rd_q_reg.offset == exp2_reg;
                emit_res.kind    = prr_pkg::KIND_DELIVER;
                emit_res.seq     = rd_q_reg.offset;
                emit_res.len     = rd_q_reg.len;
                emit_res.tag     = rd_q_reg.tag;
                emit_res.run_end = i_reg == last_del_reg;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (emit && emit_ok)
            out_reg <= emit_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            expected_reg  <= '0;
            last_seen_reg <= 1'b0;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            cur_reg       <= '0;
            exp1_reg      <= '0;
            exp2_reg      <= '0;
            dup_reg       <= 1'b0;
            any_del_reg   <= 1'b0;
            done_reg      <= 1'b0;
            i_reg         <= '0;
            m_reg         <= '0;
            last_del_reg  <= '0;
        end
        else
        begin
            if (emit && emit_ok)
                out_valid_reg <= 1'b1;
            else if (res_pop)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (pkt_valid)
                    begin
                        cur_reg     <= pkt;
                        i_reg       <= '0;
                        dup_reg     <= 1'b0;
                        any_del_reg <= 1'b0;
                        exp1_reg    <= pkt.seq + 32'(pkt.len);
                        exp2_reg    <= pkt.seq + 32'(pkt.len);
                        if (pkt.bad_ch || pkt.seq < expected_reg)
                            state_reg <= S_IDLE;
                        else if (pkt.seq == expected_reg)
                            state_reg <= S_P1_A;
                        else
                            state_reg <= S_SRCH_A;
                    end
                end
                S_SRCH_A:
                begin
                    state_reg <= (i_reg == count_reg) ? S_ACK : S_SRCH_D;
                end
                S_SRCH_D:
                begin
                    if (rd_q_reg.offset <= cur_reg.seq)
                    begin
                        dup_reg   <= rd_q_reg.offset == cur_reg.seq;
                        i_reg     <= i_reg + CNT_W'(1);
                        state_reg <= S_SRCH_A;
                    end
                    else
                        state_reg <= S_ACK;
                end
                S_ACK:
                begin
                    if (!dup_reg && count_reg == CNT_W'(TABLE_DEPTH))
                        state_reg <= S_IDLE;   // table full, dropped
                    else if (emit_ok)
                    begin
                        last_seen_reg <= last_seen_reg || cur_reg.fin;
                        if (dup_reg)
                            state_reg <= S_IDLE;
                        else
                        begin
                            m_reg     <= i_reg;   // insert position
                            i_reg     <= count_reg;
                            state_reg <= (count_reg == i_reg) ? S_INSERT : S_SHF_A;
                        end
                    end
                end
                S_SHF_A:
                begin
                    state_reg <= S_SHF_D;
                end
                S_SHF_D:
                begin
                    i_reg     <= i_reg - CNT_W'(1);
                    state_reg <= (i_reg - CNT_W'(1) == m_reg) ? S_INSERT : S_SHF_A;
                end
                S_INSERT:
                begin
                    count_reg <= count_reg + CNT_W'(1);
                    state_reg <= S_IDLE;
                end
                S_P1_A:
                begin
                    if (i_reg == count_reg)
                    begin
                        m_reg     <= i_reg;
                        done_reg  <= last_seen_reg || cur_reg.fin;
                        state_reg <= S_EM_DEL;
                    end
                    else
                        state_reg <= S_P1_D;
                end
                S_P1_D:
                begin
                    if (rd_q_reg.offset == exp1_reg)
                    begin
                        exp1_reg     <= exp1_reg + 32'(rd_q_reg.len);
                        any_del_reg  <= 1'b1;
                        last_del_reg <= i_reg;
                        i_reg        <= i_reg + CNT_W'(1);
                        state_reg    <= S_P1_A;
                    end
                    else if (rd_q_reg.offset < exp1_reg)
                    begin
                        i_reg     <= i_reg + CNT_W'(1);
                        state_reg <= S_P1_A;
                    end
                    else
                    begin
                        m_reg     <= i_reg;
                        done_reg  <= 1'b0;
                        state_reg <= S_EM_DEL;
                    end
                end
                S_EM_DEL:
                begin
                    if (emit_ok)
                        state_reg <= S_EM_ACK;
                end
                S_EM_ACK:
                begin
                    if (emit_ok)
                    begin
                        i_reg     <= '0;
                        state_reg <= S_P2_A;
                    end
                end
                S_P2_A:
                begin
                    state_reg <= (i_reg == m_reg) ? S_COMMIT : S_P2_D;
                end
                S_P2_D:
                begin
                    if (rd_q_reg.offset != exp2_reg)
                    begin
                        i_reg     <= i_reg + CNT_W'(1);   // stale entry
                        state_reg <= S_P2_A;
                    end
                    else if (emit_ok)
                    begin
                        exp2_reg  <= exp2_reg + 32'(rd_q_reg.len);
                        i_reg     <= i_reg + CNT_W'(1);
                        state_reg <= S_P2_A;
                    end
                end
                S_COMMIT:
                begin
                    head_reg      <= phys(head_reg, m_reg);
                    count_reg     <= count_reg - m_reg;
                    expected_reg  <= exp1_reg;
                    last_seen_reg <= last_seen_reg || cur_reg.fin;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- rtl/packet_reorder_receiver.sv -----
`default_nettype none
// order: the front queues and classifies a request, the back end then walks the table;
//   an in-order request gives its delivery, then its ack, then any drained deliveries
// throughput: one request at a time in the back end, which takes no new request until
//   the single-port table walk, the shift or drain and any result stalls are through;
//   a request dropped below the expected offset or for a bad channel needs no table walk
// reset: rst_n clears expected offset, last flag, table count and both queues
module packet_reorder_receiver #(
    parameter int TABLE_DEPTH  = 16,
    parameter int MAX_PAYLOAD  = 1024,
    parameter int NUM_CHANNELS = 2,
    parameter int TAG_BITS     = 8
) (
    input  wire         clk,
    input  wire         rst_n,
    // request side
    input  wire         push,
    output logic        full,
    input  wire  [31:0] seq_num,
    input  wire  [10:0] length,
    input  wire         channel,
    input  wire  [7:0]  payload_tag,
    input  wire         final_packet,
    // result side
    output logic        empty,
    input  wire         pop,
    output logic        result_kind,
    output logic [31:0] out_seq,
    output logic [10:0] out_length,
    output logic        out_channel,
    output logic [7:0]  out_tag,
    output logic        out_final,
    output logic        transfer_done,
    output logic        run_end
);
    // front to back: classified request
    logic             pkt_valid, pkt_take;
    prr_pkg::pkt_t    pkt;
    logic             res_valid;
    prr_pkg::result_t res;

    // front: input queue, length saturation, tag mask, channel check
    prr_front #(
        .MAX_PAYLOAD  (MAX_PAYLOAD),
        .NUM_CHANNELS (NUM_CHANNELS),
        .TAG_BITS     (TAG_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .seq_num      (seq_num),
        .length       (length),
        .channel      (channel),
        .payload_tag  (payload_tag),
        .final_packet (final_packet),
        .pkt_valid    (pkt_valid),
        .pkt          (pkt),
        .pkt_take     (pkt_take)
    );

    // back: reorder table walk, delivery and acknowledgement generation
    prr_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt_valid (pkt_valid),
        .pkt       (pkt),
        .pkt_take  (pkt_take),
        .res_valid (res_valid),
        .res       (res),
        .res_pop   (pop)
    );

    assign empty         = !res_valid;
    assign result_kind   = res.kind;
    assign out_seq       = res.seq;
    assign out_length    = res.len;
    assign out_channel   = res.ch;
    assign out_tag       = res.tag;
    assign out_final     = res.fin;
    assign transfer_done = res.done;
    assign run_end       = res.run_end;
endmodule
`default_nettype wire

// ----- rtl/prr_checker.sv -----
`default_nettype none
module prr_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        empty,
    input wire        pop,
    input wire        result_kind,
    input wire [31:0] out_seq,
    input wire [10:0] out_length,
    input wire        out_channel,
    input wire [7:0]  out_tag,
    input wire        out_final,
    input wire        transfer_done,
    input wire        run_end
);
    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(out_seq) && $stable(result_kind)
            && $stable(run_end))
        else $error("stalled result changed");

    // acknowledgement carries no length or tag
    a_ack: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !result_kind |-> out_length == 11'd0 && out_tag == 8'd0)
        else $error("acknowledgement with length or tag");

    // delivery carries no channel or last flag
    a_del: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result_kind |-> !out_channel && !out_final)
        else $error("delivery with channel or last flag");

    // done flag stays the same on every result of one run
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && pop && !run_end ##1 !empty |-> transfer_done == $past(transfer_done))
        else $error("done flag changed inside a run");
endmodule

bind packet_reorder_receiver prr_checker u_prr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .empty         (empty),
    .pop           (pop),
    .result_kind   (result_kind),
    .out_seq       (out_seq),
    .out_length    (out_length),
    .out_channel   (out_channel),
    .out_tag       (out_tag),
    .out_final     (out_final),
    .transfer_done (transfer_done),
    .run_end       (run_end)
);
`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
module tb;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic [31:0] seq_num = '0;
    logic [10:0] length = '0;
    logic        channel = 1'b0;
    logic [7:0]  payload_tag = '0;
    logic        final_packet = 1'b0;
    logic        pop = 1'b0;
    wire         full;
    wire         empty;
    wire         result_kind;
    wire  [31:0] out_seq;
    wire  [10:0] out_length;
    wire         out_channel;
    wire  [7:0]  out_tag;
    wire         out_final;
    wire         transfer_done;
    wire         run_end;

    packet_reorder_receiver dut (
        .clk(clk), .rst_n(rst_n),
        .push(push), .full(full),
        .seq_num(seq_num), .length(length), .channel(channel),
        .payload_tag(payload_tag), .final_packet(final_packet),
        .empty(empty), .pop(pop),
        .result_kind(result_kind), .out_seq(out_seq), .out_length(out_length),
        .out_channel(out_channel), .out_tag(out_tag), .out_final(out_final),
        .transfer_done(transfer_done), .run_end(run_end)
    );

    always #5 clk = ~clk;

    // predictor state: next expected byte offset, last flag, sorted reorder table
    logic [31:0]      next_offset;
    logic             got_last;
    prr_pkg::entry_t  reorder_tbl[$];
    prr_pkg::result_t pending_results[$];
    int               error_count = 0;

    // a test bumps this to start a long receiver hold-off
    int          hold_token = 0;
    // the sender inserts random gaps only while this is set
    bit          sender_gaps = 1'b1;

    function automatic prr_pkg::result_t make_result(logic kind, logic [31:0] seq,
                                                     logic [10:0] len, logic ch,
                                                     logic [7:0] tag, logic fin);
        prr_pkg::result_t r;
        r = '0;
        r.kind = kind;
        r.seq  = seq;
        r.len  = len;
        r.ch   = ch;
        r.tag  = tag;
        r.fin  = fin;
        return r;
    endfunction

    // work out the results for one accepted request and update the predictor
    task automatic predict_request(logic [31:0] seq, logic [10:0] len_in, logic ch,
                                   logic [7:0] tag, logic fin);
        prr_pkg::result_t batch[$];
        logic [10:0]      len;
        int               pos;
        bit               dup;
        prr_pkg::entry_t  e;
        len = (len_in > 11'd1024) ? 11'd1024 : len_in;
        if (seq < next_offset)
            return;
        if (seq == next_offset)
        begin
            batch.push_back(make_result(prr_pkg::KIND_DELIVER, seq, len, 1'b0, tag, 1'b0));
            batch.push_back(make_result(prr_pkg::KIND_ACK, seq, '0, ch, '0, fin));
            if (fin)
                got_last = 1'b1;
            next_offset = next_offset + len;
            // drain stops at the first gap, stale entries vanish silently
            while (reorder_tbl.size() > 0)
            begin
                e = reorder_tbl[0];
                if (e.offset == next_offset)
                begin
                    batch.push_back(make_result(prr_pkg::KIND_DELIVER, e.offset, e.len,
                                                1'b0, e.tag, 1'b0));
                    next_offset = next_offset + e.len;
                    void'(reorder_tbl.pop_front());
                end
                else if (e.offset < next_offset)
                    void'(reorder_tbl.pop_front());
                else
                    break;
            end
        end
        else
        begin
            pos = 0;
            while (pos < reorder_tbl.size() && reorder_tbl[pos].offset <= seq)
                pos++;
            dup = (pos > 0) && (reorder_tbl[pos-1].offset == seq);
            // table full: dropped with no acknowledgement
            if (!dup && reorder_tbl.size() >= 16)
                return;
            batch.push_back(make_result(prr_pkg::KIND_ACK, seq, '0, ch, '0, fin));
            if (fin)
                got_last = 1'b1;
            if (!dup)
            begin
                e.offset = seq;
                e.len = len;
                e.tag = tag;
                reorder_tbl.insert(pos, e);
            end
        end
        foreach (batch[i])
        begin
            batch[i].done = got_last && (reorder_tbl.size() == 0);
            batch[i].run_end = (i == batch.size() - 1);
            pending_results.push_back(batch[i]);
        end
    endtask

    // offer one request, hold it until accepted, then predict
    task automatic send_packet(logic [31:0] seq, logic [10:0] len, logic ch,
                               logic [7:0] tag, logic fin);
        push <= 1'b1;
        seq_num <= seq;
        length <= len;
        channel <= ch;
        payload_tag <= tag;
        final_packet <= fin;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_request(seq, len, ch, tag, fin);
        // random gaps between bursts; push stays high inside a burst
        if (sender_gaps && $urandom_range(0, 3) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
        end
    endtask

    task automatic go_idle();
        push <= 1'b0;
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (80)
            @(posedge clk);
    endtask

    // receiver: own stall pattern, plus a long hold-off counted here
    int pop_phase = 0;
    int hold_seen = 0;
    int hold_left = 0;
    always @(posedge clk)
    begin
        if (hold_token != hold_seen)
        begin
            hold_seen <= hold_token;
            hold_left <= 2000;
            pop <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            pop <= 1'b0;
        end
        else
        begin
            pop_phase <= pop_phase + 1;
            if (pop_phase % 64 < 20)
                pop <= 1'b1;
            else
                pop <= ($urandom_range(0, 2) != 0);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        prr_pkg::result_t exp_r;
        if (rst_n && pop && !empty)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result kind=%0d seq=%0h", result_kind, out_seq);
                error_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (result_kind !== exp_r.kind)
                begin
                    $error("result_kind exp %0d got %0d", exp_r.kind, result_kind);
                    error_count++;
                end
                if (out_seq !== exp_r.seq)
                begin
                    $error("out_seq exp %0h got %0h", exp_r.seq, out_seq);
                    error_count++;
                end
                if (out_length !== exp_r.len)
                begin
                    $error("out_length exp %0d got %0d", exp_r.len, out_length);
                    error_count++;
                end
                if (out_channel !== exp_r.ch)
                begin
                    $error("out_channel exp %0d got %0d", exp_r.ch, out_channel);
                    error_count++;
                end
                if (out_tag !== exp_r.tag)
                begin
                    $error("out_tag exp %0h got %0h", exp_r.tag, out_tag);
                    error_count++;
                end
                if (out_final !== exp_r.fin)
                begin
                    $error("out_final exp %0d got %0d", exp_r.fin, out_final);
                    error_count++;
                end
                if (transfer_done !== exp_r.done)
                begin
                    $error("transfer_done exp %0d got %0d", exp_r.done, transfer_done);
                    error_count++;
                end
                if (run_end !== exp_r.run_end)
                begin
                    $error("run_end exp %0d got %0d", exp_r.run_end, run_end);
                    error_count++;
                end
            end
        end
    end

    // corner cases: drops, gaps, stale entries, duplicates, saturation
    task automatic test_directed();
        send_packet(32'd0, 11'd0, 1'b0, 8'h00, 1'b0);       // zero length in order
        send_packet(32'd300, 11'd100, 1'b1, 8'hAA, 1'b0);   // out of order
        send_packet(32'd300, 11'd100, 1'b0, 8'h11, 1'b1);   // duplicate buffered, last
        send_packet(32'd150, 11'd50, 1'b1, 8'h55, 1'b0);    // second buffered
        send_packet(32'd120, 11'd40, 1'b0, 8'h33, 1'b0);    // overlaps next, goes stale
        send_packet(32'd0, 11'd2047, 1'b0, 8'hFF, 1'b0);    // saturates to 1024
        send_packet(32'd5, 11'd8, 1'b1, 8'h01, 1'b0);       // below offset, dropped
        send_packet(32'd5000, 11'd10, 1'b0, 8'h02, 1'b0);   // beyond the gap
        send_packet(32'd1024, 11'd1024, 1'b1, 8'hFE, 1'b1); // fills, drains to gap
        send_packet(32'd2048, 11'd2000, 1'b0, 8'h80, 1'b0);
        send_packet(32'hFFFF_FFFF, 11'd1, 1'b1, 8'h7F, 1'b1);
        wait_drained();
    endtask

    // table full: 17 out-of-order packets, then fill the gap to drain the run
    task automatic test_table_full();
        logic [31:0] base;
        base = next_offset;
        for (int i = 1; i <= 17; i++)
            send_packet(base + 32'(i * 16), 11'd16, i[0], 8'(i), 1'b0);
        send_packet(base, 11'd16, 1'b0, 8'hC3, 1'b1);
        wait_drained();
    endtask

    // long receiver hold-off while the sender keeps offering out-of-order requests
    task automatic test_backpressure();
        logic [31:0] base;
        base = next_offset;
        sender_gaps = 1'b0;
        hold_token = hold_token + 1;
        for (int i = 12; i >= 1; i--)
            send_packet(base + 32'(i * 8), 11'd8, 1'b1, 8'(i), 1'b0);
        send_packet(base, 11'd8, 1'b0, 8'h5A, 1'b0);
        sender_gaps = 1'b1;
        wait_drained();
    endtask

    // random transfers: shuffled windows of contiguous packets with some noise
    task automatic test_random(int n_items);
        logic [31:0] offs[$];
        logic [10:0] lens[$];
        int          order[$];
        logic [31:0] o;
        logic [10:0] l;
        int          sent;
        int          w;
        int          k;
        sent = 0;
        while (sent < n_items)
        begin
            offs.delete();
            lens.delete();
            order.delete();
            o = next_offset;
            w = $urandom_range(1, 12);
            for (int i = 0; i < w; i++)
            begin
                // mostly small lengths, occasionally extreme ones
                case ($urandom_range(0, 9))
                    0: l = 11'($urandom_range(1025, 2047));
                    1: l = 11'd0;
                    default: l = 11'($urandom_range(1, 64));
                endcase
                offs.push_back(o);
                lens.push_back(l);
                order.push_back(i);
                o = o + ((l > 11'd1024) ? 11'd1024 : l);
            end
            order.shuffle();
            foreach (order[i])
            begin
                // each offset keeps its own length
                k = order[i];
                if ($urandom_range(0, 7) == 0)
                    send_packet($urandom(), 11'($urandom()), 1'b1, 8'($urandom()),
                                1'($urandom()));
                else
                    send_packet(offs[k], lens[k], 1'($urandom()), 8'($urandom()),
                                ($urandom_range(0, 15) == 0));
                sent++;
            end
            // half the time, offer a packet at the expected offset to close the gap
            if (reorder_tbl.size() != 0 && $urandom_range(0, 1) == 0)
                send_packet(next_offset, 11'(reorder_tbl[0].offset - next_offset) &
                            11'h3FF, 1'($urandom()), 8'($urandom()), 1'b0);
        end
        wait_drained();
    endtask

    initial
    begin
        next_offset = '0;
        got_last = 1'b0;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_table_full();
        test_backpressure();
        test_random(400);
        if (error_count == 0)
            $display("PASS packet_reorder_receiver");
        else
            $display("FAIL packet_reorder_receiver");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("FAIL packet_reorder_receiver");
        $finish;
    end

endmodule
